/* sv/sicxe_instruction_step_top_macros.svh */
// Assertion macros for the instruction step block.
`ifndef SICXE_INSTRUCTION_STEP_TOP_MACROS_SVH
`define SICXE_INSTRUCTION_STEP_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SIS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SIS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SIS_ASSERT_SAME(label, ante, cons)
`define SIS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* sv/sis_pkg.sv */
`timescale 1ns / 1ps
package sis_pkg;
  localparam int MEM_AW = 16;
  localparam int MEM_BYTES = 1 << MEM_AW;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ = 2'd1;
  localparam logic [1:0] ACT_EXEC = 2'd2;
  localparam logic [1:0] ACT_RESTART = 2'd3;

  localparam logic [2:0] CFG_START = 3'd0;
  localparam logic [2:0] CFG_END = 3'd1;
  localparam logic [2:0] CFG_BP0 = 3'd2;
  localparam logic [2:0] CFG_BP1 = 3'd3;
  localparam logic [2:0] CFG_BP2 = 3'd4;
  localparam logic [2:0] CFG_BP3 = 3'd5;
  localparam logic [2:0] CFG_BPCNT = 3'd6;

  localparam logic [1:0] CC_NONE = 2'd0;
  localparam logic [1:0] CC_LESS = 2'd1;
  localparam logic [1:0] CC_EQUAL = 2'd2;
  localparam logic [1:0] CC_GREATER = 2'd3;

  localparam logic [7:0] OP_COMPR = 8'hA0;
  localparam logic [7:0] OP_CLEAR = 8'hB4;
  localparam logic [7:0] OP_TIXR = 8'hB8;
  localparam logic [7:0] OP_COMP = 8'h28;
  localparam logic [7:0] OP_J = 8'h3C;
  localparam logic [7:0] OP_JEQ = 8'h30;
  localparam logic [7:0] OP_JLT = 8'h38;
  localparam logic [7:0] OP_JSUB = 8'h48;
  localparam logic [7:0] OP_LDA = 8'h00;
  localparam logic [7:0] OP_LDB = 8'h68;
  localparam logic [7:0] OP_LDT = 8'h74;
  localparam logic [7:0] OP_LDCH = 8'h50;
  localparam logic [7:0] OP_RSUB = 8'h4C;
  localparam logic [7:0] OP_STA = 8'h0C;
  localparam logic [7:0] OP_STL = 8'h14;
  localparam logic [7:0] OP_STX = 8'h10;
  localparam logic [7:0] OP_STCH = 8'h54;
  localparam logic [7:0] OP_TD = 8'hE0;
  localparam logic [7:0] OP_RD = 8'hD8;
  localparam logic [7:0] OP_WD = 8'hDC;

  function automatic logic [1:0] cmp24(input logic [23:0] a, input logic [23:0] b);
    logic signed [23:0] sa;
    logic signed [23:0] sb;
    sa = a;
    sb = b;
    if (sa > sb) return CC_GREATER;
    else if (sa == sb) return CC_EQUAL;
    else return CC_LESS;
  endfunction
endpackage

/* sv/sicxe_instruction_step_top.sv */
`timescale 1ns / 1ps
// Small SIC/XE processor core with a byte memory, driven one word at a time.
// Input words carry an action (write byte, read byte, execute, restart), a
// byte address and a data byte; each accepted input word yields exactly one
// output word with the read byte, all registers but F, the condition code and the
// end, breakpoint and illegal opcode flags. Both channels use valid and stall.
// Configuration registers are written through cfg_we, cfg_index and cfg_data;
// the user must write them only while the block is idle; the block itself does not enforce this.
// One memory port with registered read data serves every access, one byte a
// cycle. A restart posts its word directly; a write stores its byte, a read
// reads it, an illegal opcode is flagged after fetch and decode, a format 2
// instruction executes after decode, and format 3 and 4 go through fetch,
// decode, target address, an optional indirect pointer read, operand access
// set-up, the operand read or write, execute and post. The next input word is
// taken in the cycle after a word is posted.
// A new input word is taken only while the sequencer is idle. If the receiver
// stalls, the result holds in the output register; the next input word is
// still taken but its result waits until the register is free.
// Reset clears the registers, the condition code and the configuration;
// memory contents are undefined until written.
module sicxe_instruction_step_top
  import sis_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [15:0] mem_address,
  input  logic [7:0]  mem_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic [23:0] acc_value,
  output logic [23:0] index_value,
  output logic [23:0] link_value,
  output logic [23:0] base_value,
  output logic [23:0] s_value,
  output logic [23:0] t_value,
  output logic [23:0] pc_value,
  output logic [1:0]  condition_code,
  output logic        reached_end,
  output logic        at_breakpoint,
  output logic        illegal_opcode
);
`include "sicxe_instruction_step_top_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_WRITE, S_DECODE, S_F2EXEC, S_TA, S_PTRSET, S_OPSEL,
    S_EXEC, S_DONE
  } state_t;

  typedef enum logic [1:0] {RK_BYTE, RK_FETCH, RK_PTR, RK_OPND} rkind_t;

  state_t state;
  rkind_t rkind;
  logic [2:0] cnt;
  logic [2:0] nbytes;
  logic [MEM_AW-1:0] maddr;
  logic [31:0] sh;
  logic [7:0] mem [MEM_BYTES];
  logic [7:0] mem_q;
  logic [7:0] ir0;
  logic [7:0] ir1;
  logic [23:0] ta;
  logic [23:0] opa;
  logic use_p, use_b, use_x, is_ill, is_exec, is_rd;

  logic [23:0] ra, rx, rl, rb, rs, rt, rf, pc;
  logic [1:0] cc;
  logic [15:0] cfg_start, cfg_end;
  logic [15:0] bp [4];
  logic [2:0] bp_count;

  logic [7:0] op;
  logic [1:0] ni;
  logic [23:0] sel_reg;
  logic [3:0] sel_num;
  logic [23:0] addend;
  logic [23:0] x_inc;
  logic [23:0] addr24;
  logic bp_hit;

  assign op = {ir0[7:2], 2'b00};
  assign ni = ir0[1:0];
  assign x_inc = rx + 24'd1;
  assign addr24 = 24'(maddr);
  assign in_stall = (state != S_IDLE);

  always_comb begin
    sel_num = (state == S_DECODE) ? sh[23:20] : ir1[3:0];
    case (sel_num)
      4'd0: sel_reg = ra;
      4'd1: sel_reg = rx;
      4'd2: sel_reg = rl;
      4'd3: sel_reg = rb;
      4'd4: sel_reg = rs;
      4'd5: sel_reg = rt;
      4'd6: sel_reg = rf;
      4'd8: sel_reg = pc;
      default: sel_reg = 24'd0;
    endcase
  end

  always_comb begin
    case (cnt)
      3'd0: addend = use_p ? pc : 24'd0;
      3'd1: addend = use_b ? rb : 24'd0;
      default: addend = use_x ? rx : 24'd0;
    endcase
  end

  always_comb begin
    bp_hit = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < bp_count && pc == {8'd0, bp[i]}) bp_hit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    mem_q <= mem[maddr];
    if (state == S_WRITE) begin
      mem[maddr] <= sh[31:24];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rkind <= RK_BYTE;
      cnt <= 3'd0;
      nbytes <= 3'd0;
      out_valid <= 1'b0;
      ra <= 24'd0; rx <= 24'd0; rl <= 24'd0; rb <= 24'd0;
      rs <= 24'd0; rt <= 24'd0; rf <= 24'd0; pc <= 24'd0;
      cc <= CC_NONE;
      cfg_start <= 16'd0;
      cfg_end <= 16'd0;
      for (int i = 0; i < 4; i++) bp[i] <= 16'd0;
      bp_count <= 3'd0;
      is_ill <= 1'b0;
      is_exec <= 1'b0;
      is_rd <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_START: cfg_start <= cfg_data;
          CFG_END: cfg_end <= cfg_data;
          CFG_BP0: bp[0] <= cfg_data;
          CFG_BP1: bp[1] <= cfg_data;
          CFG_BP2: bp[2] <= cfg_data;
          CFG_BP3: bp[3] <= cfg_data;
          CFG_BPCNT: bp_count <= cfg_data[2:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            is_ill <= 1'b0;
            is_exec <= 1'b0;
            is_rd <= 1'b0;
            cnt <= 3'd0;
            unique case (action)
              ACT_WRITE: begin
                maddr <= MEM_AW'(mem_address);
                sh <= {mem_data, 24'd0};
                nbytes <= 3'd1;
                state <= S_WRITE;
              end
              ACT_READ: begin
                maddr <= MEM_AW'(mem_address);
                nbytes <= 3'd1;
                rkind <= RK_BYTE;
                is_rd <= 1'b1;
                state <= S_READ;
              end
              ACT_EXEC: begin
                maddr <= pc[MEM_AW-1:0];
                nbytes <= 3'd4;
                rkind <= RK_FETCH;
                is_exec <= 1'b1;
                state <= S_READ;
              end
              default: begin
                ra <= 24'd0; rx <= 24'd0; rb <= 24'd0;
                rs <= 24'd0; rt <= 24'd0; rf <= 24'd0;
                rl <= {8'd0, cfg_end};
                pc <= {8'd0, cfg_start};
                state <= S_DONE;
              end
            endcase
          end
        end
        S_READ: begin
          maddr <= maddr + 1'b1;
          cnt <= cnt + 3'd1;
          if (cnt != 3'd0) sh <= {sh[23:0], mem_q};
          if (cnt == nbytes) begin
            cnt <= 3'd0;
            unique case (rkind)
              RK_FETCH: state <= S_DECODE;
              RK_PTR: state <= S_PTRSET;
              RK_OPND: state <= S_EXEC;
              default: state <= S_DONE;
            endcase
          end
        end
        S_WRITE: begin
          maddr <= maddr + 1'b1;
          sh <= {sh[23:0], 8'd0};
          cnt <= cnt + 3'd1;
          if (cnt == nbytes - 3'd1) state <= S_DONE;
        end
        S_DECODE: begin
          ir0 <= sh[31:24];
          ir1 <= sh[23:16];
          opa <= (sh[23:20] == 4'd8) ? pc + 24'd2 : sel_reg;
          cnt <= 3'd0;
          if (sh[31:24] == OP_COMPR || sh[31:24] == OP_CLEAR || sh[31:24] == OP_TIXR) begin
            pc <= pc + 24'd2;
            state <= S_F2EXEC;
          end else begin
            case ({sh[31:26], 2'b00})
              OP_COMP, OP_J, OP_JEQ, OP_JLT, OP_JSUB, OP_LDA, OP_LDB, OP_LDT,
              OP_LDCH, OP_RSUB, OP_STA, OP_STL, OP_STX, OP_STCH, OP_TD, OP_RD,
              OP_WD: begin
                use_x <= sh[23];
                state <= S_TA;
                if (sh[25:24] == 2'b00) begin
                  ta <= {9'd0, sh[22:8]};
                  use_p <= 1'b0;
                  use_b <= 1'b0;
                  pc <= pc + 24'd3;
                end else begin
                  use_p <= sh[21];
                  use_b <= sh[22];
                  if (sh[20]) begin
                    ta <= {{4{sh[19]}}, sh[19:0]};
                    pc <= pc + 24'd4;
                  end else begin
                    ta <= {{12{sh[19]}}, sh[19:8]};
                    pc <= pc + 24'd3;
                  end
                end
              end
              default: begin
                is_ill <= 1'b1;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_F2EXEC: begin
          unique case (ir0)
            OP_COMPR: cc <= cmp24(opa, sel_reg);
            OP_CLEAR: begin
              case (ir1[7:4])
                4'd0: ra <= 24'd0;
                4'd1: rx <= 24'd0;
                4'd2: rl <= 24'd0;
                4'd3: rb <= 24'd0;
                4'd4: rs <= 24'd0;
                4'd5: rt <= 24'd0;
                4'd6: rf <= 24'd0;
                4'd8: pc <= 24'd0;
                default: ;
              endcase
            end
            default: begin
              rx <= x_inc;
              cc <= cmp24(x_inc, (ir1[7:4] == 4'd1) ? x_inc : opa);
            end
          endcase
          state <= S_DONE;
        end
        S_TA: begin
          ta <= ta + addend;
          cnt <= cnt + 3'd1;
          if (cnt == 3'd2) begin
            cnt <= 3'd0;
            state <= S_PTRSET;
            if (ni == 2'b10) begin
              maddr <= ta[MEM_AW-1:0] + addend[MEM_AW-1:0];
              nbytes <= 3'd3;
              rkind <= RK_PTR;
              state <= S_READ;
            end
          end
        end
        S_PTRSET: begin
          maddr <= (ni == 2'b10) ? sh[MEM_AW-1:0] : ta[MEM_AW-1:0];
          state <= S_OPSEL;
        end
        S_OPSEL: begin
          cnt <= 3'd0;
          state <= S_EXEC;
          case (op)
            OP_COMP, OP_LDA, OP_LDB, OP_LDT: begin
              if (ni != 2'b01) begin
                nbytes <= 3'd3;
                rkind <= RK_OPND;
                state <= S_READ;
              end
            end
            OP_LDCH: begin
              if (ni != 2'b01) begin
                nbytes <= 3'd1;
                rkind <= RK_OPND;
                state <= S_READ;
              end
            end
            OP_STA: begin sh <= {ra, 8'd0}; nbytes <= 3'd3; state <= S_WRITE; end
            OP_STL: begin sh <= {rl, 8'd0}; nbytes <= 3'd3; state <= S_WRITE; end
            OP_STX: begin sh <= {rx, 8'd0}; nbytes <= 3'd3; state <= S_WRITE; end
            OP_STCH: begin sh <= {ra[7:0], 24'd0}; nbytes <= 3'd1; state <= S_WRITE; end
            default: ;
          endcase
        end
        S_EXEC: begin
          case (op)
            OP_COMP: cc <= cmp24(ra, (ni == 2'b01) ? ta : sh[23:0]);
            OP_J: pc <= addr24;
            OP_JEQ: if (cc == CC_EQUAL) pc <= addr24;
            OP_JLT: if (cc == CC_LESS) pc <= addr24;
            OP_JSUB: begin rl <= pc; pc <= addr24; end
            OP_LDA: ra <= (ni == 2'b01) ? ta : sh[23:0];
            OP_LDB: rb <= (ni == 2'b01) ? ta : sh[23:0];
            OP_LDT: rt <= (ni == 2'b01) ? ta : sh[23:0];
            OP_LDCH: ra[7:0] <= (ni == 2'b01) ? ta[7:0] : sh[7:0];
            OP_RSUB: pc <= rl;
            OP_TD: cc <= CC_LESS;
            default: ;
          endcase
          state <= S_DONE;
        end
        default: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            read_data <= is_rd ? sh[7:0] : 8'd0;
            acc_value <= ra;
            index_value <= rx;
            link_value <= rl;
            base_value <= rb;
            s_value <= rs;
            t_value <= rt;
            pc_value <= pc;
            condition_code <= cc;
            reached_end <= is_exec && (pc == {8'd0, cfg_end});
            at_breakpoint <= is_exec && bp_hit;
            illegal_opcode <= is_ill;
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  `SIS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `SIS_ASSERT_SAME(a_read_no_flags, out_valid && read_data != 8'd0,
                   !reached_end && !at_breakpoint && !illegal_opcode)
  `SIS_ASSERT_SAME(a_illegal_alone, out_valid && illegal_opcode, read_data == 8'd0)

endmodule
